// ----- design/orb_pkg.sv -----
// ----------------------------------------------------------------------------
// orb_pkg
// Shared types and constants of the overwriting ring buffer unit.
// ----------------------------------------------------------------------------
`default_nettype none

package orb_pkg;

  // Default storage geometry
  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Fixed payload field widths
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CAP_W   = 5;
  localparam int unsigned COUNT_W = 5;

  // Operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH = 2'd0,
    FUNC_POP  = 2'd1,
    FUNC_PEEK = 2'd2
  } func_e;

endpackage

`default_nettype wire

// ----- design/orb_ifs.sv -----
// ----------------------------------------------------------------------------
// orb_ifs
// Valid/ready channels of the ring buffer: request, response, capacity write.
// ----------------------------------------------------------------------------
`default_nettype none

interface orb_req_if import orb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [WORD_W-1:0] push_data;

  modport source (output valid, output func, output push_data, input ready);
  modport sink   (input valid, input func, input push_data, output ready);
endinterface

interface orb_rsp_if import orb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               ok;
  logic               dropped;
  logic [WORD_W-1:0]  out_data;
  logic [COUNT_W-1:0] count;
  logic               is_empty;
  logic               is_full;

  modport source (output valid, output ok, output dropped, output out_data,
                  output count, output is_empty, output is_full, input ready);
  modport sink   (input valid, input ok, input dropped, input out_data,
                  input count, input is_empty, input is_full, output ready);
endinterface

interface orb_cfg_if import orb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- design/overwriting_ring_buffer_unit.sv -----
// ----------------------------------------------------------------------------
// overwriting_ring_buffer_unit
// Ring FIFO with programmable capacity; a push into a full buffer overwrites
// the oldest item. Pop removes the oldest item, peek only reads it.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    func, push_data
//   out_o    out  valid/ready    ok, dropped, out_data, count, is_empty, is_full
//   cfg_i    in   valid/ready    data (capacity), always ready
//
// One item per cycle while out_o is not stalled; each response appears in the
// cycle after its item is taken, its data from the registered RAM read port.
// Pointers and the full flag update at accept; the RAM read returns the data.
// A stalled response holds the pipeline: in_i.ready drops until out_o is taken.
// Reset empties the buffer and sets capacity to DEPTH; no clearing pass.
// A capacity write empties the buffer as well.
// ----------------------------------------------------------------------------
`default_nettype none

module overwriting_ring_buffer_unit
  import orb_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  orb_req_if.sink    in_i,
  orb_rsp_if.source  out_o,
  orb_cfg_if.sink    cfg_i
);

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CapW = $clog2(DEPTH + 1);
  localparam int unsigned MemW = (DATA_WIDTH < WORD_W) ? DATA_WIDTH : WORD_W;

  // Pointer state
  logic [CapW-1:0] cap_q, cap_d;
  logic [IdxW-1:0] head_q, head_d;
  logic [IdxW-1:0] tail_q, tail_d;
  logic            full_q, full_d;

  // Response stage
  logic               rsp_valid_q;
  logic               ok_q, ok_d;
  logic               dropped_q, dropped_d;
  logic               rd_q, rd_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic               empty_q, empty_d;
  logic               isfull_q, isfull_d;

  logic            accept;
  logic            we, re;
  logic [MemW-1:0] rdata;
  logic [IdxW-1:0] head_inc, tail_inc;
  logic [CapW-1:0] held;
  logic [31:0]     cfg_ext;
  logic [CapW-1:0] cfg_cap;

  assign accept      = in_i.valid && in_i.ready;
  assign in_i.ready  = !rsp_valid_q || out_o.ready;
  assign cfg_i.ready = 1'b1;

  // Clamp the written capacity into 1..DEPTH
  assign cfg_ext = 32'(cfg_i.data);
  always_comb begin
    if (cfg_ext == 32'd0) begin
      cfg_cap = CapW'(1);
    end else if (cfg_ext > DEPTH) begin
      cfg_cap = CapW'(DEPTH);
    end else begin
      cfg_cap = CapW'(cfg_ext);
    end
  end

  // Wrap pointers at the active capacity
  assign head_inc = (CapW'(head_q) + CapW'(1) == cap_q) ? '0 : IdxW'(head_q + 1'b1);
  assign tail_inc = (CapW'(tail_q) + CapW'(1) == cap_q) ? '0 : IdxW'(tail_q + 1'b1);

  // Apply the operation and build the response
  always_comb begin
    cap_d     = cap_q;
    head_d    = head_q;
    tail_d    = tail_q;
    full_d    = full_q;
    ok_d      = 1'b0;
    dropped_d = 1'b0;
    rd_d      = 1'b0;
    we        = 1'b0;
    re        = 1'b0;
    if (cfg_i.valid) begin
      cap_d  = cfg_cap;
      head_d = '0;
      tail_d = '0;
      full_d = 1'b0;
    end else if (accept) begin
      case (func_e'(in_i.func))
        FUNC_PUSH: begin
          we     = 1'b1;
          ok_d   = 1'b1;
          tail_d = tail_inc;
          if (full_q) begin
            head_d    = head_inc;
            dropped_d = 1'b1;
          end else begin
            full_d = (head_q == tail_inc);
          end
        end
        FUNC_POP, FUNC_PEEK: begin
          if (full_q || head_q != tail_q) begin
            re   = 1'b1;
            rd_d = 1'b1;
            ok_d = 1'b1;
            if (func_e'(in_i.func) == FUNC_POP) begin
              head_d = head_inc;
              full_d = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Occupancy after the operation
  always_comb begin
    if (full_d) begin
      held = cap_q;
    end else if (tail_d >= head_d) begin
      held = CapW'(tail_d) - CapW'(head_d);
    end else begin
      held = CapW'(tail_d) + cap_q - CapW'(head_d);
    end
    count_d  = COUNT_W'(held);
    empty_d  = !full_d && (head_d == tail_d);
    isfull_d = (held == cap_q);
  end

  // Pointer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CapW'(DEPTH);
      head_q <= '0;
      tail_q <= '0;
      full_q <= 1'b0;
    end else begin
      cap_q  <= cap_d;
      head_q <= head_d;
      tail_q <= tail_d;
      full_q <= full_d;
    end
  end

  // Response valid: set on accept, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (accept) begin
      rsp_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  // Response payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q      <= ok_d;
      dropped_q <= dropped_d;
      rd_q      <= rd_d;
      count_q   <= count_d;
      empty_q   <= empty_d;
      isfull_q  <= isfull_d;
    end
  end

  // Slot storage
  orb_ram #(
    .Width (MemW),
    .Depth (DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (tail_q),
    .wdata_i (in_i.push_data[MemW-1:0]),
    .re_i    (re),
    .raddr_i (head_q),
    .rdata_o (rdata)
  );

  assign out_o.valid    = rsp_valid_q;
  assign out_o.ok       = ok_q;
  assign out_o.dropped  = dropped_q;
  assign out_o.out_data = rd_q ? WORD_W'(rdata) : '0;
  assign out_o.count    = count_q;
  assign out_o.is_empty = empty_q;
  assign out_o.is_full  = isfull_q;

endmodule

`default_nettype wire

// ----- design/orb_ram.sv -----
// ----------------------------------------------------------------------------
// orb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module orb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- verif/orb_ring_checker.sv -----
// ----------------------------------------------------------------------------
// orb_ring_checker
// Watches the request, response and capacity channels of the ring buffer,
// predicts every response from its own copy of the FIFO state and compares
// the responses in order, field by field.
// ----------------------------------------------------------------------------

module orb_ring_checker
  import orb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  orb_req_if   req_mon,
  orb_rsp_if   rsp_mon,
  orb_cfg_if   cfg_mon,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o,
  output int   dropped_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = DEPTH_DEF;
  localparam int unsigned IDX_W = $clog2(DEPTH);

  typedef struct packed {
    logic               ok;
    logic               dropped;
    logic [WORD_W-1:0]  out_data;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
    logic               is_full;
  } orb_rsp_t;

  // Shadow FIFO state
  logic [WORD_W-1:0] slot_mem [DEPTH];
  logic [IDX_W-1:0]  head_idx;
  logic [IDX_W-1:0]  tail_idx;
  logic              full_flag;
  logic [CAP_W-1:0]  cap_reg;

  orb_rsp_t pending_rsp_q [$];
  orb_rsp_t want_rsp;

  int mismatch_cnt = 0;
  int checked_cnt  = 0;
  int dropped_cnt  = 0;
  int pending_cnt  = 0;

  assign fail_count_o = mismatch_cnt;
  assign pending_o    = pending_cnt;
  assign checked_o    = checked_cnt;
  assign dropped_o    = dropped_cnt;

  // Apply one operation to the shadow FIFO and return the response it causes
  function automatic orb_rsp_t ring_apply_op(input logic [FUNC_W-1:0] op,
                                             input logic [WORD_W-1:0] word);
    int unsigned cap_eff;
    int unsigned h;
    int unsigned t;
    int unsigned n;
    orb_rsp_t    r;
    r = '0;
    // a capacity of zero acts as one, anything above the depth as the depth
    if (cap_reg == '0) begin
      cap_eff = 1;
    end else if (cap_reg > DEPTH) begin
      cap_eff = DEPTH;
    end else begin
      cap_eff = cap_reg;
    end
    h = head_idx % cap_eff;
    t = tail_idx % cap_eff;
    case (op)
      FUNC_PUSH: begin
        slot_mem[t] = word;
        t = (t + 1) % cap_eff;
        // full buffer: overwrite the oldest word and advance the head
        if (full_flag) begin
          h = (h + 1) % cap_eff;
          r.dropped = 1'b1;
        end else begin
          full_flag = (h == t);
        end
        r.ok = 1'b1;
      end
      FUNC_POP, FUNC_PEEK: begin
        if (full_flag || h != t) begin
          r.out_data = slot_mem[h];
          if (op == FUNC_POP) begin
            h = (h + 1) % cap_eff;
            full_flag = 1'b0;
          end
          r.ok = 1'b1;
        end
      end
      default: begin
        // unused code: state holds, only the status is reported
      end
    endcase
    head_idx = h[IDX_W-1:0];
    tail_idx = t[IDX_W-1:0];
    n = full_flag ? cap_eff : (t + cap_eff - h) % cap_eff;
    r.count    = n[COUNT_W-1:0];
    r.is_empty = !full_flag && (h == t);
    r.is_full  = (n == cap_eff);
    return r;
  endfunction

  function automatic void check_field(input string field, input logic [WORD_W-1:0] want,
                                      input logic [WORD_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
      mismatch_cnt++;
    end
  endfunction

  // Track writes and requests, then check the response taken at this edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_idx  = '0;
      tail_idx  = '0;
      full_flag = 1'b0;
      cap_reg   = CAP_W'(DEPTH);
      pending_rsp_q.delete();
      pending_cnt = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        cap_reg   = cfg_mon.data;
        head_idx  = '0;
        tail_idx  = '0;
        full_flag = 1'b0;
      end
      if (req_mon.valid && req_mon.ready) begin
        pending_rsp_q.push_back(ring_apply_op(req_mon.func, req_mon.push_data));
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (pending_rsp_q.size() == 0) begin
          $error("response item with no request outstanding");
          mismatch_cnt++;
        end else begin
          want_rsp = pending_rsp_q.pop_front();
          check_field("ok", WORD_W'(want_rsp.ok), WORD_W'(rsp_mon.ok));
          check_field("dropped", WORD_W'(want_rsp.dropped), WORD_W'(rsp_mon.dropped));
          check_field("out_data", want_rsp.out_data, rsp_mon.out_data);
          check_field("count", WORD_W'(want_rsp.count), WORD_W'(rsp_mon.count));
          check_field("is_empty", WORD_W'(want_rsp.is_empty), WORD_W'(rsp_mon.is_empty));
          check_field("is_full", WORD_W'(want_rsp.is_full), WORD_W'(rsp_mon.is_full));
          checked_cnt++;
          if (want_rsp.dropped) begin
            dropped_cnt++;
          end
        end
      end
      pending_cnt = pending_rsp_q.size();
    end
  end

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stimulus for the overwriting ring buffer: a directed pass over empty,
// full, overwrite and unused-code cases, then random push/pop/peek streams
// under several capacities and idle mixes. The checker does the comparing.
// ----------------------------------------------------------------------------

module tb;

  import orb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [FUNC_W-1:0] FUNC_RSVD = 2'd3;
  localparam int SEG_ITEMS = 217;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  int snd_idle_pct = 22;
  int rcv_idle_pct = 63;
  int ops_sent     = 0;
  int cap_writes   = 0;

  int fail_count;
  int pending_rsp;
  int checked_rsp;
  int dropped_rsp;

  logic [CAP_W-1:0] seg_caps [9];

  orb_req_if req_if();
  orb_rsp_if rsp_if();
  orb_cfg_if cfg_if();

  overwriting_ring_buffer_unit u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_if),
    .out_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  orb_ring_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_mon      (req_if),
    .rsp_mon      (rsp_if),
    .cfg_mon      (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending_rsp),
    .checked_o    (checked_rsp),
    .dropped_o    (dropped_rsp)
  );

  always #5 clk = ~clk;

  // Stall the response channel at random
  always @(negedge clk) begin
    rsp_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // Offer one request item and hold it until taken; starts and ends at a falling edge
  task automatic send_op(input logic [FUNC_W-1:0] op, input logic [WORD_W-1:0] word);
    while ($urandom_range(99) < snd_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.func      <= op;
    req_if.push_data <= word;
    @(posedge clk);
    while (!req_if.ready) begin
      @(posedge clk);
    end
    @(negedge clk);
    ops_sent++;
  endtask

  // Drop valid and hold off until every outstanding response has come back
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(negedge clk);
    while (pending_rsp != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    wait_drained();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) begin
      @(posedge clk);
    end
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    cap_writes++;
  endtask

  // Random stream under one capacity, drifting between fill and drain phases
  task automatic run_stream(input logic [CAP_W-1:0] cap_value, input int n_items);
    mix_e              mix;
    int                pick;
    int                push_lim;
    logic [FUNC_W-1:0] op;
    logic [WORD_W-1:0] word;
    mix = MIX_EVEN;
    write_capacity(cap_value);
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        mix = mix_e'($urandom_range(2));
      end
      case (mix)
        MIX_FILL:  push_lim = 75;
        MIX_DRAIN: push_lim = 35;
        default:   push_lim = 56;
      endcase
      pick = $urandom_range(99);
      if (pick < 3) begin
        op = FUNC_RSVD;
      end else if (pick < 13) begin
        op = FUNC_PEEK;
      end else if (pick < push_lim) begin
        op = FUNC_PUSH;
      end else begin
        op = FUNC_POP;
      end
      if ($urandom_range(19) == 0) begin
        word = $urandom_range(1) ? '1 : '0;
      end else begin
        word = $urandom;
      end
      // let the pipeline run dry now and then
      if (i == n_items / 2 || $urandom_range(149) == 0) begin
        wait_drained();
      end
      send_op(op, word);
    end
  endtask

  initial begin
    req_if.valid     = 1'b0;
    req_if.func      = FUNC_PUSH;
    req_if.push_data = '0;
    cfg_if.valid     = 1'b0;
    cfg_if.data      = '0;
    rsp_if.ready     = 1'b0;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset capacity: failures on empty, unused code, extreme words
    send_op(FUNC_POP, 32'h1234_5678);
    send_op(FUNC_PEEK, '0);
    send_op(FUNC_RSVD, '1);
    send_op(FUNC_PUSH, '0);
    send_op(FUNC_PUSH, '1);
    send_op(FUNC_RSVD, 32'hDEAD_BEEF);
    send_op(FUNC_PEEK, '0);
    send_op(FUNC_POP, '0);
    send_op(FUNC_POP, '0);
    send_op(FUNC_POP, '0);

    // Capacity zero acts as one: second push overwrites
    write_capacity('0);
    send_op(FUNC_PUSH, 32'hA5A5_A5A5);
    send_op(FUNC_PUSH, 32'h5A5A_5A5A);
    send_op(FUNC_PEEK, '0);
    send_op(FUNC_POP, '0);
    send_op(FUNC_PEEK, '0);

    // Capacity two: fill, overwrite twice, drain past empty
    write_capacity(5'd2);
    send_op(FUNC_PUSH, 32'h0000_0001);
    send_op(FUNC_PUSH, 32'h8000_0000);
    send_op(FUNC_PUSH, 32'h7FFF_FFFF);
    send_op(FUNC_PUSH, 32'hFFFF_FFFE);
    send_op(FUNC_POP, '0);
    send_op(FUNC_POP, '0);
    send_op(FUNC_POP, '0);

    seg_caps = '{5'd1, 5'd16, 5'd31, 5'd0, 5'd5, 5'd20, 5'd2, 5'd9,
                 CAP_W'($urandom_range(31))};
    for (int s = 0; s < 9; s++) begin
      if (s == 3) begin
        snd_idle_pct = 63;
        rcv_idle_pct = 22;
      end else if (s == 6) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      run_stream(seg_caps[s], SEG_ITEMS);
    end

    wait_drained();
    repeat (8) @(negedge clk);

    $display("summary: %0d requests under %0d capacity writes, %0d responses checked",
             ops_sent, cap_writes, checked_rsp);
    $display("summary: %0d overwrites predicted; idle mixes 22/63, 63/22 and none",
             dropped_rsp);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
